/* hdl/symmetric_fir_multichannel_macros.svh */
// Assertion macros used by the checker file of the filter.
`ifndef SYMMETRIC_FIR_MULTICHANNEL_MACROS_SVH
`define SYMMETRIC_FIR_MULTICHANNEL_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/sfir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfir_pkg;

   localparam int TAPS_HALF_DEF = 6;
   localparam int CHANNELS_DEF  = 4;

   localparam int DATA_W    = 16;
   localparam int COEF_W    = 18;
   localparam int NUM_COEF  = 6;
   localparam int CSR_IDX_W = 3;

   // Pre-added pair, pair times coefficient, and the sum of up to eight products.
   localparam int PRE_W  = DATA_W + 1;
   localparam int PROD_W = PRE_W + COEF_W;
   localparam int ACC_W  = PROD_W + 3;

   localparam int RND_SHIFT = 15;
   localparam int RND_ADD   = 16384;

   localparam int R1_W = ACC_W - RND_SHIFT;
   localparam int GP_W = R1_W + COEF_W;

   localparam logic signed [COEF_W-1:0] NORM_GAIN_RESET = 18'sd32768;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_4    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_5    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_GAIN = 3'd6;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SUM   = 5'b00010,
      S_ROUND = 5'b00100,
      S_GAIN  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

/* hdl/sfir_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfir_cell #(
   parameter int CHANNELS = sfir_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift_en,
   input  logic signed [sfir_pkg::DATA_W-1:0]  fwd_src,
   output logic signed [sfir_pkg::DATA_W-1:0]  fwd_dst,
   input  logic signed [sfir_pkg::DATA_W-1:0]  back_src,
   output logic signed [sfir_pkg::DATA_W-1:0]  back_dst,
   input  logic signed [sfir_pkg::COEF_W-1:0]  coef,
   input  logic signed [sfir_pkg::ACC_W-1:0]   psum_src,
   output logic signed [sfir_pkg::ACC_W-1:0]   psum_dst
);
   import sfir_pkg::*;

   // Each cell holds one channel-interleaved segment of the forward half of the
   // delay line and one of the backward half. The head of each segment is a tap.
   logic signed [DATA_W-1:0] fwd_ff  [CHANNELS];
   logic signed [DATA_W-1:0] back_ff [CHANNELS];

   logic signed [PRE_W-1:0]  pre_sum;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  psum_in;
   logic signed [ACC_W-1:0]  psum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            fwd_ff[i]  <= '0;
            back_ff[i] <= '0;
         end
      end else if (shift_en) begin
         fwd_ff[0]  <= fwd_src;
         back_ff[0] <= back_src;
         for (int i = 1; i < CHANNELS; i++) begin
            fwd_ff[i]  <= fwd_ff[i-1];
            back_ff[i] <= back_ff[i-1];
         end
      end
   end

   assign fwd_dst  = fwd_ff[CHANNELS-1];
   assign back_dst = back_ff[CHANNELS-1];

   assign pre_sum = PRE_W'(fwd_ff[0]) + PRE_W'(back_ff[0]);
   assign prod_in = PROD_W'(pre_sum) * PROD_W'(coef);

   // The partial sum moves one cell toward the output each cycle.
   assign psum_in = ACC_W'(prod_ff) + psum_src;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      psum_ff <= psum_in;
   end

   assign psum_dst = psum_ff;

endmodule

`default_nettype wire

/* hdl/symmetric_fir_multichannel.sv */
// Symmetric FIR filter over channel-interleaved 16-bit samples. Each accepted
// request shifts one sample into a folded delay line held in a row of TAPS_HALF
// cells; each cell pre-adds its symmetric tap pair and multiplies it by its
// coefficient, and the products are summed through a partial-sum chain that
// moves one cell per cycle. The sum is rounded to Q15, scaled by norm_gain,
// rounded again and delivered as the low 16 bits. A result is registered once
// its request has passed the partial-sum chain and the rounding and gain
// stages, and no new request is taken until that result is loaded. A waiting
// result does not block the next request. Registers (index: coef_0..coef_5
// at 0..5, norm_gain at 6) are written through the csr port; the user must
// write them only while the filter is idle, which the block does not enforce.
// csr_ready is always high and writes to index 7 are ignored.
`timescale 1ns / 1ps
`default_nettype none

module symmetric_fir_multichannel #(
   parameter int TAPS_HALF = sfir_pkg::TAPS_HALF_DEF,
   parameter int CHANNELS  = sfir_pkg::CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sfir_pkg::DATA_W-1:0]           req_tdata,   // [15:0] sample_in
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sfir_pkg::DATA_W-1:0]           rsp_tdata,   // [15:0] sample_out
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sfir_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sfir_pkg::COEF_W-1:0]           csr_data
);
   import sfir_pkg::*;

   localparam int CNT_W = $clog2(TAPS_HALF + 1);

   logic signed [COEF_W-1:0] coef_ff [NUM_COEF];
   logic signed [COEF_W-1:0] norm_gain_ff;

   logic signed [DATA_W-1:0] fwd_link  [TAPS_HALF+1];
   logic signed [DATA_W-1:0] back_link [TAPS_HALF+1];
   logic signed [ACC_W-1:0]  psum_link [TAPS_HALF+1];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic                    req_fire;
   logic                    out_load;
   logic signed [ACC_W-1:0] sum1;
   logic signed [R1_W-1:0]  r1_ff;
   logic signed [GP_W-1:0]  gp_in;
   logic signed [GP_W-1:0]  gp_ff;
   logic signed [GP_W-1:0]  sum2;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
         norm_gain_ff <= NORM_GAIN_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_NORM_GAIN) begin
            norm_gain_ff <= csr_data;
         end else if (csr_index <= CSR_COEF_5) begin
            coef_ff[csr_index] <= csr_data;
         end
      end
   end

   // Row of cells. The forward half runs from cell 0 to the last cell, folds
   // there and runs back toward cell 0.
   assign req_fire             = req_tvalid && req_tready;
   assign fwd_link[0]          = req_tdata;
   assign back_link[TAPS_HALF] = fwd_link[TAPS_HALF];
   assign psum_link[TAPS_HALF] = '0;

   for (genvar k = 0; k < TAPS_HALF; k++) begin : g_cell
      sfir_cell #(
         .CHANNELS (CHANNELS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_fire),
         .fwd_src  (fwd_link[k]),
         .fwd_dst  (fwd_link[k+1]),
         .back_src (back_link[k+1]),
         .back_dst (back_link[k]),
         .coef     (coef_ff[k]),
         .psum_src (psum_link[k+1]),
         .psum_dst (psum_link[k])
      );
   end

   // Rounding and gain stages run freely; the state machine only decides when
   // their contents are meaningful.
   assign sum1  = psum_link[0] + ACC_W'(RND_ADD);
   assign gp_in = GP_W'(r1_ff) * GP_W'(norm_gain_ff);
   assign sum2  = gp_ff + GP_W'(RND_ADD);

   always_ff @(posedge clock) begin
      r1_ff <= sum1[ACC_W-1:RND_SHIFT];
      gp_ff <= gp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SUM;
               cnt_in   = '0;
            end
         end
         S_SUM: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TAPS_HALF)) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            state_in = S_GAIN;
         end
         S_GAIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= sum2[RND_SHIFT+DATA_W-1:RND_SHIFT];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/sfir_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "symmetric_fir_multichannel_macros.svh"

module sfir_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [sfir_pkg::DATA_W-1:0]  rsp_tdata
);

   // A stalled result keeps its value.
   `SFIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // Only one request is in flight: an accepted request closes the input.
   `SFIR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while one was in flight")

   // A new result is only produced by a request in flight.
   `SFIR_ASSERT_NOW(a_rsp_from_req, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared with no request in flight")

   // The result cannot arrive on the cycle right after its request.
   `SFIR_ASSERT_NEXT(a_min_latency, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "result produced too early")

endmodule

bind symmetric_fir_multichannel sfir_checker u_sfir_checker (.*);

`default_nettype wire
